/* sv/rabd_pkg.sv */
`timescale 1ns / 1ps

package rabd_pkg;

  typedef enum logic {
    REQ_STRAIGHT = 1'b0,
    REQ_PREMUL   = 1'b1
  } req_type_e;

  // One input item as it enters the blend pipeline
  typedef struct packed {
    logic        req_type;
    logic [15:0] dst_pixel;
    logic [31:0] src_color;
    logic [7:0]  opacity;
    logic        dither_enable;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
  } pix_req_t;

  // Blended 8-bit channels handed to the packer
  typedef struct packed {
    logic        bypass;
    logic [15:0] dst_pixel;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic        dither_enable;
    logic [1:0]  bayer_x;
    logic [1:0]  bayer_y;
  } blend_t;

  localparam logic [15:0] ROUND_BIAS = 16'd127;
  localparam logic [15:0] RECIP_255  = 16'd32897;  // ceil(2^23 / 255)
  localparam int unsigned RECIP_SH   = 23;

  localparam logic [3:0] BAYER_TAB [4][4] = '{
    '{4'd0,  4'd8,  4'd2,  4'd10},
    '{4'd12, 4'd4,  4'd14, 4'd6},
    '{4'd3,  4'd11, 4'd1,  4'd9},
    '{4'd15, 4'd7,  4'd13, 4'd5}
  };

  // a*b + 127, ready for a divide by 255
  function automatic logic [15:0] mul_bias(input logic [7:0] a, input logic [7:0] b);
    mul_bias = 16'(a) * 16'(b) + ROUND_BIAS;
  endfunction

  // floor(x / 255) by reciprocal; exact for x below 66052, result fits 8 bits here
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [31:0] p;
    p = 32'(x) * 32'(RECIP_255);
    div255 = p[RECIP_SH +: 8];
  endfunction

  function automatic logic [7:0] expand5(input logic [4:0] v);
    expand5 = {v, v[4:2]};
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] v);
    expand6 = {v, v[5:4]};
  endfunction

endpackage

/* sv/rabd_if.sv */
`timescale 1ns / 1ps

interface rabd_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] dst_pixel;
  logic [31:0] src_color;
  logic [7:0]  opacity;
  logic        dither_enable;
  logic [7:0]  pixel_x;
  logic [7:0]  pixel_y;

  modport source (
    output valid, req_type, dst_pixel, src_color, opacity, dither_enable, pixel_x, pixel_y,
    input  ready
  );
  modport sink (
    input  valid, req_type, dst_pixel, src_color, opacity, dither_enable, pixel_x, pixel_y,
    output ready
  );
endinterface

interface rabd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_pixel;

  modport source (output valid, out_pixel, input ready);
  modport sink (input valid, out_pixel, output ready);
endinterface

/* sv/rabd_blend.sv */
`timescale 1ns / 1ps

module rabd_blend import rabd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pix_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output blend_t   out_data_o
);

  // stage 1: products with bias, destination expand
  logic        s1_v_q;
  req_type_e   s1_mode_q;
  logic [15:0] s1_dst_q;
  logic        s1_dith_q;
  logic [1:0]  s1_bx_q, s1_by_q;
  logic [15:0] s1_pa_q, s1_pr_q, s1_pg_q, s1_pb_q;
  logic [7:0]  s1_sr_q, s1_sg_q, s1_sb_q;
  logic [7:0]  s1_dr_q, s1_dg_q, s1_db_q;

  // stage 2: effective alpha and scaled source
  logic        s2_v_q;
  req_type_e   s2_mode_q;
  logic [15:0] s2_dst_q;
  logic        s2_dith_q;
  logic [1:0]  s2_bx_q, s2_by_q;
  logic [7:0]  s2_ea_q, s2_inv_q;
  logic [7:0]  s2_srop_q, s2_sgop_q, s2_sbop_q;
  logic [7:0]  s2_sr_q, s2_sg_q, s2_sb_q;
  logic [7:0]  s2_dr_q, s2_dg_q, s2_db_q;

  // stage 3: blend sums
  logic        s3_v_q;
  req_type_e   s3_mode_q;
  logic [15:0] s3_dst_q;
  logic        s3_dith_q;
  logic [1:0]  s3_bx_q, s3_by_q;
  logic        s3_bypass_q;
  logic [15:0] s3_sum_r_q, s3_sum_g_q, s3_sum_b_q;
  logic [7:0]  s3_srop_q, s3_sgop_q, s3_sbop_q;

  // stage 4: final channels
  logic        s4_v_q;
  blend_t      s4_data_q;

  logic s1_en, s2_en, s3_en, s4_en;

  assign s4_en      = !s4_v_q || out_ready_i;
  assign s3_en      = !s3_v_q || s4_en;
  assign s2_en      = !s2_v_q || s3_en;
  assign s1_en      = !s1_v_q || s2_en;
  assign in_ready_o = s1_en;

  assign out_valid_o = s4_v_q;
  assign out_data_o  = s4_data_q;

  logic [7:0] a_sr, a_sg, a_sb, a_sa;
  assign a_sr = in_req_i.src_color[31:24];
  assign a_sg = in_req_i.src_color[23:16];
  assign a_sb = in_req_i.src_color[15:8];
  assign a_sa = in_req_i.src_color[7:0];

  logic [15:0] c_sum_r, c_sum_g, c_sum_b;
  logic [15:0] c_src_r, c_src_g, c_src_b;

  always_comb begin
    if (s2_mode_q == REQ_PREMUL) begin
      c_src_r = 16'd0;
      c_src_g = 16'd0;
      c_src_b = 16'd0;
    end else begin
      c_src_r = 16'(s2_sr_q) * 16'(s2_ea_q);
      c_src_g = 16'(s2_sg_q) * 16'(s2_ea_q);
      c_src_b = 16'(s2_sb_q) * 16'(s2_ea_q);
    end
    c_sum_r = c_src_r + 16'(s2_dr_q) * 16'(s2_inv_q) + ROUND_BIAS;
    c_sum_g = c_src_g + 16'(s2_dg_q) * 16'(s2_inv_q) + ROUND_BIAS;
    c_sum_b = c_src_b + 16'(s2_db_q) * 16'(s2_inv_q) + ROUND_BIAS;
  end

  logic [7:0] d_q_r, d_q_g, d_q_b;
  logic [8:0] d_t_r, d_t_g, d_t_b;
  blend_t     s4_data_d;

  always_comb begin
    d_q_r = div255(s3_sum_r_q);
    d_q_g = div255(s3_sum_g_q);
    d_q_b = div255(s3_sum_b_q);
    d_t_r = 9'(s3_srop_q) + 9'(d_q_r);
    d_t_g = 9'(s3_sgop_q) + 9'(d_q_g);
    d_t_b = 9'(s3_sbop_q) + 9'(d_q_b);
    s4_data_d.bypass        = s3_bypass_q;
    s4_data_d.dst_pixel     = s3_dst_q;
    s4_data_d.dither_enable = s3_dith_q;
    s4_data_d.bayer_x       = s3_bx_q;
    s4_data_d.bayer_y       = s3_by_q;
    if (s3_mode_q == REQ_PREMUL) begin
      // saturate premultiplied sums
      s4_data_d.r = d_t_r[8] ? 8'hFF : d_t_r[7:0];
      s4_data_d.g = d_t_g[8] ? 8'hFF : d_t_g[7:0];
      s4_data_d.b = d_t_b[8] ? 8'hFF : d_t_b[7:0];
    end else begin
      s4_data_d.r = d_q_r;
      s4_data_d.g = d_q_g;
      s4_data_d.b = d_q_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (s1_en) s1_v_q <= in_valid_i;
      if (s2_en) s2_v_q <= s1_v_q;
      if (s3_en) s3_v_q <= s2_v_q;
      if (s4_en) s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_mode_q <= req_type_e'(in_req_i.req_type);
      s1_dst_q  <= in_req_i.dst_pixel;
      s1_dith_q <= in_req_i.dither_enable;
      s1_bx_q   <= in_req_i.pixel_x[1:0];
      s1_by_q   <= in_req_i.pixel_y[1:0];
      s1_pa_q   <= mul_bias(a_sa, in_req_i.opacity);
      s1_pr_q   <= mul_bias(a_sr, in_req_i.opacity);
      s1_pg_q   <= mul_bias(a_sg, in_req_i.opacity);
      s1_pb_q   <= mul_bias(a_sb, in_req_i.opacity);
      s1_sr_q   <= a_sr;
      s1_sg_q   <= a_sg;
      s1_sb_q   <= a_sb;
      s1_dr_q   <= expand5(in_req_i.dst_pixel[15:11]);
      s1_dg_q   <= expand6(in_req_i.dst_pixel[10:5]);
      s1_db_q   <= expand5(in_req_i.dst_pixel[4:0]);
    end
    if (s2_en && s1_v_q) begin
      s2_mode_q <= s1_mode_q;
      s2_dst_q  <= s1_dst_q;
      s2_dith_q <= s1_dith_q;
      s2_bx_q   <= s1_bx_q;
      s2_by_q   <= s1_by_q;
      s2_ea_q   <= div255(s1_pa_q);
      s2_inv_q  <= 8'hFF - div255(s1_pa_q);
      s2_srop_q <= div255(s1_pr_q);
      s2_sgop_q <= div255(s1_pg_q);
      s2_sbop_q <= div255(s1_pb_q);
      s2_sr_q   <= s1_sr_q;
      s2_sg_q   <= s1_sg_q;
      s2_sb_q   <= s1_sb_q;
      s2_dr_q   <= s1_dr_q;
      s2_dg_q   <= s1_dg_q;
      s2_db_q   <= s1_db_q;
    end
    if (s3_en && s2_v_q) begin
      s3_mode_q   <= s2_mode_q;
      s3_dst_q    <= s2_dst_q;
      s3_dith_q   <= s2_dith_q;
      s3_bx_q     <= s2_bx_q;
      s3_by_q     <= s2_by_q;
      s3_bypass_q <= (s2_ea_q == 8'd0);
      s3_sum_r_q  <= c_sum_r;
      s3_sum_g_q  <= c_sum_g;
      s3_sum_b_q  <= c_sum_b;
      s3_srop_q   <= s2_srop_q;
      s3_sgop_q   <= s2_sgop_q;
      s3_sbop_q   <= s2_sbop_q;
    end
    if (s4_en && s3_v_q) begin
      s4_data_q <= s4_data_d;
    end
  end

endmodule

/* sv/rabd_pack.sv */
`timescale 1ns / 1ps

module rabd_pack import rabd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  blend_t      in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_pixel_o
);

  function automatic logic [7:0] rem255(input logic [13:0] vm, input logic [7:0] q);
    rem255 = 8'(vm - 14'(q) * 14'd255);
  endfunction

  // stage 5: quotient, remainder, threshold
  logic        s5_v_q;
  logic        s5_bypass_q;
  logic        s5_dith_q;
  logic [15:0] s5_dst_q;
  logic [15:0] s5_trunc_q;
  logic [4:0]  s5_qr_q, s5_qb_q;
  logic [5:0]  s5_qg_q;
  logic [7:0]  s5_remr_q, s5_remg_q, s5_remb_q;
  logic [12:0] s5_thr_q;

  // stage 6: output register
  logic        s6_v_q;
  logic [15:0] s6_pix_q;

  logic s5_en, s6_en;
  assign s6_en       = !s6_v_q || out_ready_i;
  assign s5_en       = !s5_v_q || s6_en;
  assign in_ready_o  = s5_en;
  assign out_valid_o = s6_v_q;
  assign out_pixel_o = s6_pix_q;

  logic [13:0] e_vm_r, e_vm_g, e_vm_b;
  logic [7:0]  e_q_r, e_q_g, e_q_b;
  logic [12:0] e_thr;

  always_comb begin
    e_vm_r = 14'(in_data_i.r) * 14'd31;
    e_vm_g = 14'(in_data_i.g) * 14'd63;
    e_vm_b = 14'(in_data_i.b) * 14'd31;
    e_q_r  = div255(16'(e_vm_r));
    e_q_g  = div255(16'(e_vm_g));
    e_q_b  = div255(16'(e_vm_b));
    e_thr  = 13'({BAYER_TAB[in_data_i.bayer_y][in_data_i.bayer_x], 1'b1}) * 13'd255;
  end

  logic       f_up_r, f_up_g, f_up_b;
  logic [15:0] f_dith;
  logic [15:0] s6_pix_d;

  always_comb begin
    // raise the quotient when the remainder clears the Bayer threshold
    f_up_r = (s5_qr_q < 5'd31) && ({s5_remr_q, 5'b0} > s5_thr_q);
    f_up_g = (s5_qg_q < 6'd63) && ({s5_remg_q, 5'b0} > s5_thr_q);
    f_up_b = (s5_qb_q < 5'd31) && ({s5_remb_q, 5'b0} > s5_thr_q);
    f_dith = {s5_qr_q + 5'(f_up_r), s5_qg_q + 6'(f_up_g), s5_qb_q + 5'(f_up_b)};
    if (s5_bypass_q) begin
      s6_pix_d = s5_dst_q;
    end else if (s5_dith_q) begin
      s6_pix_d = f_dith;
    end else begin
      s6_pix_d = s5_trunc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
    end else begin
      if (s5_en) s5_v_q <= in_valid_i;
      if (s6_en) s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s5_en && in_valid_i) begin
      s5_bypass_q <= in_data_i.bypass;
      s5_dith_q   <= in_data_i.dither_enable;
      s5_dst_q    <= in_data_i.dst_pixel;
      s5_trunc_q  <= {in_data_i.r[7:3], in_data_i.g[7:2], in_data_i.b[7:3]};
      s5_qr_q     <= e_q_r[4:0];
      s5_qg_q     <= e_q_g[5:0];
      s5_qb_q     <= e_q_b[4:0];
      s5_remr_q   <= rem255(e_vm_r, e_q_r);
      s5_remg_q   <= rem255(e_vm_g, e_q_g);
      s5_remb_q   <= rem255(e_vm_b, e_q_b);
      s5_thr_q    <= e_thr;
    end
    if (s6_en && s5_v_q) begin
      s6_pix_q <= s6_pix_d;
    end
  end

endmodule

/* sv/rgb565_alpha_blend_dither_unit.sv */
`timescale 1ns / 1ps

// RGB565 alpha blend with 4x4 ordered dither.
// Four blend stages, two pack stages. Throughput: one item per clock while the sink is ready.
// Each of the two 8x8 multiply-and-divide-by-255 steps per channel puts its multiply and its
// divide in separate stages, and ready runs combinationally from the sink back to the input.
// Reset clears only the valid bits of every stage; payload registers are not reset.

module rgb565_alpha_blend_dither_unit import rabd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  rabd_in_if.sink    pix_in_i,
  rabd_out_if.source pix_out_o
);

  pix_req_t in_req;
  blend_t   blend_data;
  logic     blend_valid;
  logic     blend_ready;

  // Gather the input item into one request word
  always_comb begin
    in_req.req_type      = pix_in_i.req_type;
    in_req.dst_pixel     = pix_in_i.dst_pixel;
    in_req.src_color     = pix_in_i.src_color;
    in_req.opacity       = pix_in_i.opacity;
    in_req.dither_enable = pix_in_i.dither_enable;
    in_req.pixel_x       = pix_in_i.pixel_x;
    in_req.pixel_y       = pix_in_i.pixel_y;
  end

  // Blend: effective alpha, per-channel mix, rounding and saturation
  rabd_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_in_i.valid),
    .in_ready_o  (pix_in_i.ready),
    .in_req_i    (in_req),
    .out_valid_o (blend_valid),
    .out_ready_i (blend_ready),
    .out_data_o  (blend_data)
  );

  // Pack: truncate or dither to RGB565, pass the destination on a transparent source
  rabd_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (blend_valid),
    .in_ready_o  (blend_ready),
    .in_data_i   (blend_data),
    .out_valid_o (pix_out_o.valid),
    .out_ready_i (pix_out_o.ready),
    .out_pixel_o (pix_out_o.out_pixel)
  );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

// Blend/dither unit testbench: a short table of hand-picked pixels, then
// a long random stream. Expected pixels come from the table where it has
// one, else from a behavioral predictor here, matched in order to the output.
module tb_top;
  import rabd_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 1730;
  localparam int unsigned QUIET_TAIL     = 250;   // last items run with no idling
  localparam int unsigned PHASE_LEN      = 150;   // items per idling phase
  localparam int unsigned DRAIN_CYCLES   = 20;    // pipeline is 6 deep, allow margin
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // 4x4 ordered-dither thresholds, entry (row*4 + col) at bits [4*idx +: 4]
  localparam logic [63:0] THRESH_MAP = {
    4'd5, 4'd13, 4'd7,  4'd15,
    4'd9, 4'd1,  4'd11, 4'd3,
    4'd6, 4'd14, 4'd4,  4'd12,
    4'd10, 4'd2, 4'd8,  4'd0
  };

  logic clk_i;
  logic rst_ni;

  rabd_in_if  pix_in ();
  rabd_out_if pix_out ();

  rgb565_alpha_blend_dither_unit i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_in_i  (pix_in),
    .pix_out_o (pix_out)
  );

  // One row of the directed table; pix is used only when known is set
  typedef struct {
    pix_req_t    req;
    bit          known;
    logic [15:0] pix;
  } stim_row_t;

  // One expected output pixel, tagged with the input item number
  typedef struct {
    int unsigned tag;
    logic [15:0] pix;
  } pending_pix_t;

  stim_row_t    stim_tab[$];
  pending_pix_t pending_pix[$];

  int unsigned err_cnt     = 0;
  int unsigned sent_cnt    = 0;
  int unsigned checked_cnt = 0;
  int unsigned premul_cnt  = 0;
  int unsigned dither_cnt  = 0;
  int unsigned clear_cnt   = 0;
  int unsigned stall_cnt   = 0;
  bit          idle_on     = 1'b0;

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Rounded a*b/255 on 8-bit operands
  function automatic int unsigned scale_255(int unsigned a, int unsigned b);
    return (a * b + 127) / 255;
  endfunction

  // Quantize an 8-bit channel to 0..lvl_max, rounding up when the
  // fractional part beats the Bayer threshold
  function automatic int unsigned ordered_quant(int unsigned v, int unsigned lvl_max,
                                                int unsigned thr);
    int unsigned q;
    int unsigned rem;
    q   = v * lvl_max / 255;
    rem = v * lvl_max - 255 * q;
    if (q < lvl_max && 32 * rem > (2 * thr + 1) * 255) q++;
    return q;
  endfunction

  function automatic logic [15:0] blend_pixel(pix_req_t p);
    int unsigned s_ch[3];
    int unsigned d_ch[3];
    int unsigned o_ch[3];
    int unsigned eff_a;
    int unsigned inv_a;
    int unsigned thr;
    logic [4:0]  d_r5;
    logic [5:0]  d_g6;
    logic [4:0]  d_b5;
    s_ch[0] = p.src_color[31:24];
    s_ch[1] = p.src_color[23:16];
    s_ch[2] = p.src_color[15:8];
    eff_a   = scale_255(p.src_color[7:0], p.opacity);
    // Fully transparent: the destination goes through untouched
    if (eff_a == 0) return p.dst_pixel;
    inv_a = 255 - eff_a;
    // Widen the destination by bit replication
    d_r5    = p.dst_pixel[15:11];
    d_g6    = p.dst_pixel[10:5];
    d_b5    = p.dst_pixel[4:0];
    d_ch[0] = {d_r5, d_r5[4:2]};
    d_ch[1] = {d_g6, d_g6[5:4]};
    d_ch[2] = {d_b5, d_b5[4:2]};
    for (int c = 0; c < 3; c++) begin
      if (p.req_type == REQ_STRAIGHT) begin
        o_ch[c] = (s_ch[c] * eff_a + d_ch[c] * inv_a + 127) / 255;
      end else begin
        o_ch[c] = scale_255(s_ch[c], p.opacity) + scale_255(d_ch[c], inv_a);
        if (o_ch[c] > 255) o_ch[c] = 255;
      end
    end
    if (!p.dither_enable) begin
      return {5'(o_ch[0] >> 3), 6'(o_ch[1] >> 2), 5'(o_ch[2] >> 3)};
    end
    thr = THRESH_MAP[{p.pixel_y[1:0], p.pixel_x[1:0], 2'b00} +: 4];
    return {5'(ordered_quant(o_ch[0], 31, thr)), 6'(ordered_quant(o_ch[1], 63, thr)),
            5'(ordered_quant(o_ch[2], 31, thr))};
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, int unsigned tag, logic [15:0] got,
                                 logic [15:0] want);
    $display("ERROR @%0t item %0d: %s, got %h expected %h", $realtime, tag, what, got, want);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  task automatic add_stim(bit mode, logic [15:0] dst, logic [31:0] src, logic [7:0] op,
                          bit dith, logic [7:0] x, logic [7:0] y, bit known,
                          logic [15:0] pix);
    stim_row_t row;
    row.req.req_type      = mode;
    row.req.dst_pixel     = dst;
    row.req.src_color     = src;
    row.req.opacity       = op;
    row.req.dither_enable = dith;
    row.req.pixel_x       = x;
    row.req.pixel_y       = y;
    row.known             = known;
    row.pix               = pix;
    stim_tab.push_back(row);
  endtask

  task automatic build_stim_tab();
    // Transparent source: destination back unchanged in either mode
    add_stim(REQ_STRAIGHT, 16'hABCD, 32'h1234_5600, 8'hFF, 1'b1, 8'd5, 8'd6, 1'b1, 16'hABCD);
    add_stim(REQ_PREMUL,   16'h1234, 32'hFFFF_FFFF, 8'h00, 1'b0, 8'd0, 8'd0, 1'b1, 16'h1234);
    add_stim(REQ_PREMUL,   16'h7BEF, 32'hFFFF_FF00, 8'hFF, 1'b1, 8'd2, 8'd1, 1'b1, 16'h7BEF);
    // Alpha 1 with opacity 127 rounds to zero, with 128 it does not
    add_stim(REQ_STRAIGHT, 16'h5A5A, 32'hFFFF_FF01, 8'd127, 1'b0, 8'd0, 8'd0, 1'b1, 16'h5A5A);
    add_stim(REQ_STRAIGHT, 16'h0000, 32'h80C0_E001, 8'd128, 1'b0, 8'd0, 8'd0, 1'b0, '0);
    // Opaque extremes
    add_stim(REQ_STRAIGHT, 16'h0000, 32'hFFFF_FFFF, 8'hFF, 1'b0, 8'd0, 8'd0, 1'b1, 16'hFFFF);
    add_stim(REQ_STRAIGHT, 16'hFFFF, 32'h0000_00FF, 8'hFF, 1'b0, 8'd0, 8'd0, 1'b1, 16'h0000);
    add_stim(REQ_STRAIGHT, 16'h0000, 32'hFFFF_FFFF, 8'hFF, 1'b1, 8'd3, 8'd3, 1'b1, 16'hFFFF);
    add_stim(REQ_STRAIGHT, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, 8'd0, 8'd0, 1'b1, 16'hFFFF);
    add_stim(REQ_PREMUL,   16'hFFFF, 32'h0000_00FF, 8'hFF, 1'b1, 8'd0, 8'd0, 1'b1, 16'h0000);
    add_stim(REQ_STRAIGHT, 16'h1234, 32'h8080_80FF, 8'hFF, 1'b0, 8'd0, 8'd0, 1'b1, 16'h8410);
    // Premultiplied sources, some with a channel above its alpha, where the sum clamps at 255
    add_stim(REQ_PREMUL,   16'hFFFF, 32'hFFFF_FF80, 8'hFF, 1'b0, 8'd0, 8'd0, 1'b1, 16'hFFFF);
    add_stim(REQ_PREMUL,   16'h0000, 32'hFFFF_FF40, 8'hC0, 1'b0, 8'd0, 8'd0, 1'b0, '0);
    add_stim(REQ_PREMUL,   16'h8410, 32'h4030_2040, 8'hFF, 1'b0, 8'd0, 8'd0, 1'b0, '0);
    add_stim(REQ_PREMUL,   16'h5555, 32'hF0F0_F0FF, 8'h80, 1'b1, 8'd3, 8'd2, 1'b0, '0);
    // Dithered mid-tones at several Bayer cells
    add_stim(REQ_STRAIGHT, 16'h0000, 32'h7F7F_7FFF, 8'hFF, 1'b1, 8'd0, 8'd0, 1'b0, '0);
    add_stim(REQ_STRAIGHT, 16'h0000, 32'h7F7F_7FFF, 8'hFF, 1'b1, 8'd1, 8'd1, 1'b0, '0);
    add_stim(REQ_STRAIGHT, 16'h0000, 32'h7F7F_7FFF, 8'hFF, 1'b1, 8'd2, 8'd3, 1'b0, '0);
    add_stim(REQ_STRAIGHT, 16'h0000, 32'h7F7F_7FFF, 8'hFF, 1'b1, 8'd3, 8'd0, 1'b0, '0);
    add_stim(REQ_STRAIGHT, 16'h001F, 32'hFF00_0080, 8'hFF, 1'b1, 8'd2, 8'd1, 1'b0, '0);
    add_stim(REQ_STRAIGHT, 16'hAAAA, 32'h1234_56FF, 8'hFF, 1'b1, 8'd1, 8'd2, 1'b0, '0);
    // Coordinates beyond the frame: only the low two bits matter
    add_stim(REQ_STRAIGHT, 16'hF800, 32'h4080_C0FF, 8'hFF, 1'b1, 8'd255, 8'd255, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Random pixels
  // ---------------------------------------------------------------------------

  // Bias toward zero, full and near-zero values so the rounding edges get hit
  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(1, 3));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t row;
    logic [7:0] alpha;
    bit         well_formed;
    alpha       = pick_level();
    row.req.req_type  = 1'($urandom_range(0, 1));
    row.req.dst_pixel = 16'($urandom);
    row.req.opacity   = pick_level();
    // Premultiplied sources mostly keep color at or below alpha
    well_formed = (row.req.req_type == REQ_PREMUL) && ($urandom_range(0, 3) != 0);
    if (well_formed) begin
      row.req.src_color = {8'($urandom_range(0, alpha)), 8'($urandom_range(0, alpha)),
                           8'($urandom_range(0, alpha)), alpha};
    end else begin
      row.req.src_color = {24'($urandom), alpha};
    end
    row.req.dither_enable = 1'($urandom_range(0, 1));
    row.req.pixel_x = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 239));
    row.req.pixel_y = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 134));
    row.known = 1'b0;
    row.pix   = '0;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------------

  // Drive one item at a rising edge, hold it until ready is seen high at the
  // falling edge, then log its expectation; it is taken at the next rising edge.
  task automatic send_pixel(stim_row_t row);
    int unsigned  gap;
    pending_pix_t want;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      pix_in.valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(posedge clk_i);
    end
    pix_in.valid         <= 1'b1;
    pix_in.req_type      <= row.req.req_type;
    pix_in.dst_pixel     <= row.req.dst_pixel;
    pix_in.src_color     <= row.req.src_color;
    pix_in.opacity       <= row.req.opacity;
    pix_in.dither_enable <= row.req.dither_enable;
    pix_in.pixel_x       <= row.req.pixel_x;
    pix_in.pixel_y       <= row.req.pixel_y;
    do @(negedge clk_i); while (pix_in.ready !== 1'b1);
    want.tag = sent_cnt;
    want.pix = row.known ? row.pix : blend_pixel(row.req);
    pending_pix.push_back(want);
    sent_cnt++;
    if (row.req.req_type == REQ_PREMUL) premul_cnt++;
    if (row.req.dither_enable) dither_cnt++;
    if (scale_255(row.req.src_color[7:0], row.req.opacity) == 0) clear_cnt++;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Output sink: random back-pressure in bursts, ready driven low for whole cycles
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    hold_left     = 0;
    pix_out.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        pix_out.ready <= 1'b0;
        hold_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        pix_out.ready <= 1'b0;
        hold_left = $urandom_range(0, 2);
      end else begin
        pix_out.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output checker: sample at the falling edge, where both sides are settled
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : out_check
    pending_pix_t want;
    if (rst_ni && pix_out.valid === 1'b1 && pix_out.ready === 1'b1) begin
      if (pending_pix.size() == 0) begin
        report_mismatch("unexpected pixel", sent_cnt, pix_out.out_pixel, 'x);
      end else begin
        want = pending_pix.pop_front();
        checked_cnt++;
        if (pix_out.out_pixel !== want.pix) begin
          report_mismatch("out_pixel", want.tag, pix_out.out_pixel, want.pix);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: count cycles in which neither side moves an item
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni || (pix_in.valid === 1'b1 && pix_in.ready === 1'b1) ||
        (pix_out.valid === 1'b1 && pix_out.ready === 1'b1)) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
      if (stall_cnt >= WATCHDOG_LIMIT) begin
        $display("ERROR: no item moved for %0d cycles, %0d pixels outstanding",
                 WATCHDOG_LIMIT, pending_pix.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t row;
    rst_ni               = 1'b0;
    pix_in.valid         = 1'b0;
    pix_in.req_type      = REQ_STRAIGHT;
    pix_in.dst_pixel     = '0;
    pix_in.src_color     = '0;
    pix_in.opacity       = '0;
    pix_in.dither_enable = 1'b0;
    pix_in.pixel_x       = '0;
    pix_in.pixel_y       = '0;

    // Hold reset low, then release it on a rising edge
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table with idling on both sides
    build_stim_tab();
    idle_on = 1'b1;
    foreach (stim_tab[i]) send_pixel(stim_tab[i]);

    // Random stream: idle in two of every three phases, none at the tail
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on = (i + QUIET_TAIL < RANDOM_ITEMS) && ((i / PHASE_LEN) % 3 != 2);
      row = random_row();
      send_pixel(row);
    end

    // Drop valid, let the pipeline drain, then give stragglers time to show
    pix_in.valid <= 1'b0;
    idle_on = 1'b0;
    while (pending_pix.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d pixels: %0d premultiplied, %0d dithered, %0d fully transparent.",
             sent_cnt, premul_cnt, dither_cnt, clear_cnt);
    $display("Compared %0d output pixels, %0d mismatches.", checked_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/rabd_pkg.sv
sv/rabd_if.sv
sv/rabd_blend.sv
sv/rabd_pack.sv
sv/rgb565_alpha_blend_dither_unit.sv
dv/tb_top.sv
